// ===== hw/rtl/ip_address_text_parser_macros.svh =====
// Assertion helpers for the address text parser.
// Both expect clk and rst_n in scope at the point of use.
`ifndef IP_ADDRESS_TEXT_PARSER_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_MACROS_SVH

// Same-cycle implication.
`define IPAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipat_pkg.sv =====
package ipat_pkg;

    localparam int NUM_GROUPS = 8;
    localparam int GROUP_W    = 16;
    localparam int NUM_OCTETS = 4;
    localparam logic [3:0] COLON_MAX = 4'd15;

    // classified character, one queue entry
    typedef struct packed {
        logic       has_char;
        logic       is_colon;
        logic       is_dot;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
        logic       last;
    } ipat_item_t;

    // parse state frozen at end of text
    typedef struct packed {
        logic                                colon_seen;
        logic [31:0]                         v4_value;
        logic [NUM_GROUPS-1:0][GROUP_W-1:0]  left;
        logic [NUM_GROUPS-1:0][GROUP_W-1:0]  right;
        logic [3:0]                          left_count;
        logic [3:0]                          right_count;
        logic [3:0]                          left_sep_cnt;
        logic [3:0]                          right_sep_cnt;
        logic                                left_any;
        logic                                right_any;
        logic                                compressed;
    } ipat_snap_t;

endpackage

// ===== hw/rtl/ipat_channels.sv =====
interface ipat_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_text;

    modport source (output valid, output text_byte, output byte_valid,
                    output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input byte_valid,
                    input end_of_text, output ready);
endinterface

interface ipat_result_if;
    logic        valid;
    logic        ready;
    logic        is_ipv6;
    logic [31:0] ipv4_value;
    logic [63:0] ipv6_upper;
    logic [63:0] ipv6_lower;

    modport source (output valid, output is_ipv6, output ipv4_value,
                    output ipv6_upper, output ipv6_lower, input ready);
    modport sink   (input valid, input is_ipv6, input ipv4_value,
                    input ipv6_upper, input ipv6_lower, output ready);
endinterface

// ===== hw/rtl/ipat_front.sv =====
module ipat_front
    import ipat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ipat_char_if.sink    chars,
    output logic         item_valid,
    output ipat_item_t   item,
    input  logic         item_ready
);

    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_DOT      = 8'h2E;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_A_LOWER  = 8'h61;
    localparam logic [7:0] CHAR_F_LOWER  = 8'h66;
    localparam logic [7:0] CHAR_CASE_BIT = 8'h20;
    localparam logic [3:0] ALPHA_OFFSET  = 4'd9;

    logic       item_valid_reg;
    logic       item_valid_next;
    ipat_item_t item_reg;
    ipat_item_t item_next;
    logic [7:0] lower;
    logic       is_dec;
    logic       is_alpha;
    logic       take;

    assign chars.ready = !item_valid_reg || item_ready;
    assign take        = chars.valid && chars.ready;

    assign lower    = chars.text_byte | CHAR_CASE_BIT;
    assign is_dec   = (chars.text_byte >= CHAR_ZERO) && (chars.text_byte <= CHAR_NINE);
    assign is_alpha = (lower >= CHAR_A_LOWER) && (lower <= CHAR_F_LOWER);

    always_comb
    begin
        item_next.has_char = chars.byte_valid;
        item_next.is_colon = chars.byte_valid && (chars.text_byte == CHAR_COLON);
        item_next.is_dot   = chars.byte_valid && (chars.text_byte == CHAR_DOT);
        item_next.is_dec   = chars.byte_valid && is_dec;
        item_next.is_hex   = chars.byte_valid && (is_dec || is_alpha);
        // 'a' and 'A' have low nibble 1
        item_next.digit    = is_dec ? chars.text_byte[3:0]
                                    : chars.text_byte[3:0] + ALPHA_OFFSET;
        item_next.last     = chars.end_of_text;
    end

    assign item_valid_next = take ? 1'b1 : (item_ready ? 1'b0 : item_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/ipat_queue.sv =====
module ipat_queue
    import ipat_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ipat_item_t in_item,
    output logic       in_ready,
    output logic       out_valid,
    output ipat_item_t out_item,
    input  logic       out_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipat_item_t             entries [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/ipat_back.sv =====
module ipat_back
    import ipat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  ipat_item_t item,
    output logic       item_ready,
    output logic       snap_valid,
    output ipat_snap_t snap,
    input  logic       snap_ready
);

    typedef struct packed {
        logic                                colon_seen;
        logic [NUM_OCTETS-1:0][7:0]          v4_oct;
        logic [2:0]                          v4_idx;
        logic [GROUP_W-1:0]                  acc;
        logic                                open;
        logic                                prev_colon;
        logic                                compressed;
        logic                                stopped;
        logic [NUM_GROUPS-1:0][GROUP_W-1:0]  left;
        logic [3:0]                          lc;
        logic [3:0]                          lcol;
        logic [NUM_GROUPS-1:0][GROUP_W-1:0]  right;
        logic [3:0]                          rc;
        logic [3:0]                          rcol;
        logic                                left_any;
        logic                                right_any;
    } ipat_parse_t;

    // close the open group into whichever side is current
    function automatic ipat_parse_t commit(input ipat_parse_t s);
        ipat_parse_t r;
        r = s;
        if (s.open)
        begin
            if (s.compressed)
            begin
                if (!s.rc[3])
                begin
                    r.right[s.rc[2:0]] = s.acc;
                    r.rc = s.rc + 4'd1;
                end
            end
            else
            begin
                if (!s.lc[3])
                begin
                    r.left[s.lc[2:0]] = s.acc;
                    r.lc = s.lc + 4'd1;
                end
            end
            r.open = 1'b0;
            r.acc  = '0;
        end
        return r;
    endfunction

    function automatic ipat_parse_t take_hex(input ipat_parse_t s, input ipat_item_t it);
        ipat_parse_t r;
        r = s;
        if (it.is_hex)
        begin
            r.acc  = s.open ? {s.acc[GROUP_W-5:0], it.digit} : {{(GROUP_W-4){1'b0}}, it.digit};
            r.open = 1'b1;
        end
        else
        begin
            r = commit(s);
            r.stopped = 1'b1;
        end
        return r;
    endfunction

    function automatic ipat_parse_t step_char(input ipat_parse_t s, input ipat_item_t it);
        ipat_parse_t r;
        logic [7:0]  oct;
        r   = s;
        oct = s.v4_oct[s.v4_idx[1:0]];
        if (it.is_colon)
        begin
            r.colon_seen = 1'b1;
        end
        // v4: octet index of four means done
        if (!s.v4_idx[2])
        begin
            if (it.is_dot)
            begin
                r.v4_idx = s.v4_idx + 3'd1;
            end
            else if (it.is_dec)
            begin
                r.v4_oct[s.v4_idx[1:0]] = (oct << 3) + (oct << 1) + {4'd0, it.digit};
            end
        end
        // v6
        if (!s.compressed)
        begin
            if (!s.stopped)
            begin
                if (it.is_colon)
                begin
                    if (s.prev_colon)
                    begin
                        r.prev_colon = 1'b0;
                        r.compressed = 1'b1;
                    end
                    else
                    begin
                        r = commit(r);
                        r.prev_colon = 1'b1;
                    end
                end
                else
                begin
                    if (s.prev_colon)
                    begin
                        r.prev_colon = 1'b0;
                        if (s.lcol != COLON_MAX)
                        begin
                            r.lcol = s.lcol + 4'd1;
                        end
                    end
                    r.left_any = 1'b1;
                    r = take_hex(r, it);
                end
            end
        end
        else
        begin
            r.right_any = 1'b1;
            if (it.is_colon)
            begin
                if (s.rcol != COLON_MAX)
                begin
                    r.rcol = s.rcol + 4'd1;
                end
                if (!s.stopped)
                begin
                    r = commit(r);
                end
            end
            else if (!s.stopped)
            begin
                r = take_hex(r, it);
            end
        end
        return r;
    endfunction

    ipat_parse_t state_reg;
    ipat_parse_t state_next;
    ipat_parse_t after_char;
    ipat_parse_t final_st;
    logic        snap_valid_reg;
    logic        snap_valid_next;
    ipat_snap_t  snap_reg;
    ipat_snap_t  snap_next;
    logic        pop;
    logic        pop_last;

    // a last transaction needs a free snapshot slot
    assign item_ready = !item.last || !snap_valid_reg || snap_ready;
    assign pop        = item_valid && item_ready;
    assign pop_last   = pop && item.last;

    always_comb
    begin
        after_char = item.has_char ? step_char(state_reg, item) : state_reg;
        final_st   = after_char.stopped ? after_char : commit(after_char);

        if (pop)
        begin
            state_next = item.last ? '0 : after_char;
        end
        else
        begin
            state_next = state_reg;
        end

        snap_next.colon_seen    = final_st.colon_seen;
        snap_next.v4_value      = {final_st.v4_oct[0], final_st.v4_oct[1],
                                   final_st.v4_oct[2], final_st.v4_oct[3]};
        snap_next.left          = final_st.left;
        snap_next.right         = final_st.right;
        snap_next.left_count    = final_st.lc;
        snap_next.right_count   = final_st.rc;
        snap_next.left_sep_cnt  = final_st.lcol;
        snap_next.right_sep_cnt = final_st.rcol;
        snap_next.left_any      = final_st.left_any;
        snap_next.right_any     = final_st.right_any;
        snap_next.compressed    = final_st.compressed;
    end

    assign snap_valid_next = pop_last ? 1'b1 : (snap_ready ? 1'b0 : snap_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_last)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== hw/rtl/ipat_finish.sv =====
module ipat_finish
    import ipat_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          snap_valid,
    input  ipat_snap_t    snap,
    output logic          snap_ready,
    ipat_result_if.source result
);

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               is_ipv6_reg;
    logic [31:0]                        ipv4_reg;
    logic [63:0]                        upper_reg;
    logic [63:0]                        lower_reg;
    logic [5:0]                         left_part_cnt;
    logic [5:0]                         right_part_cnt;
    logic signed [6:0]                  start;
    logic                               place_ok;
    logic [NUM_GROUPS:0]                ones;
    logic [NUM_GROUPS-1:0]              present;
    logic [NUM_GROUPS-1:0]              covered;
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] placed;
    logic [NUM_GROUPS-1:0][GROUP_W-1:0] seg;
    logic                               load;

    assign snap_ready = !out_valid_reg || result.ready;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        left_part_cnt  = snap.left_any  ? {2'b00, snap.left_sep_cnt}  + 6'd1 : 6'd0;
        right_part_cnt = snap.right_any ? {2'b00, snap.right_sep_cnt} + 6'd1 : 6'd0;
        start          = signed'({3'b000, snap.left_count}) + 7'sd8
                         - signed'({1'b0, left_part_cnt}) - signed'({1'b0, right_part_cnt});
        place_ok       = snap.compressed && (start[6:3] == 4'd0);

        // right group i lands on segment start + i
        ones    = (NUM_GROUPS + 1)'(1) << snap.right_count;
        present = NUM_GROUPS'(ones - (NUM_GROUPS + 1)'(1));
        covered = present << start[2:0];
        placed  = snap.right << {start[2:0], 4'b0000};

        for (int j = 0; j < NUM_GROUPS; j++)
        begin
            seg[j] = (place_ok && covered[j]) ? placed[j] : snap.left[j];
        end
    end

    assign out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_ipv6_reg <= snap.colon_seen;
            ipv4_reg    <= snap.colon_seen ? 32'd0 : snap.v4_value;
            upper_reg   <= snap.colon_seen ? {seg[0], seg[1], seg[2], seg[3]} : 64'd0;
            lower_reg   <= snap.colon_seen ? {seg[4], seg[5], seg[6], seg[7]} : 64'd0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.is_ipv6    = is_ipv6_reg;
    assign result.ipv4_value = ipv4_reg;
    assign result.ipv6_upper = upper_reg;
    assign result.ipv6_lower = lower_reg;

endmodule

// ===== hw/rtl/ip_address_text_parser.sv =====
// IP address text parser, one character per transaction.
// chars:  text_byte with byte_valid; end_of_text marks the last transaction of
//         one address. byte_valid low adds no character (empty end marker).
// result: one transaction per text: is_ipv6 (a colon was seen), ipv4_value,
//         ipv6_upper / ipv6_lower (segment 0 in the top bits). Fields of the
//         kind not chosen are zero.
// Path: the last character passes the front register, the queue, the parse
//         stage + snapshot and the placement into the output register.
// Throughput: one character per cycle, sustained while no end-of-text entry
//         waits for a free snapshot slot; set by the single parse stage,
//         which retires one queue entry each cycle.
// Stall: if result is held off, the output register and the snapshot stage
//         fill; the parse stage then holds only at an end-of-text entry, and
//         the queue and front register back up until chars.ready drops.
// Reset: async, active low; all parse state is zero and no result pending.
//         Parse state also returns to zero after every end of text.
`include "ip_address_text_parser_macros.svh"

module ip_address_text_parser
    import ipat_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    ipat_char_if.sink     chars,
    ipat_result_if.source result
);

    // front -> queue
    logic       front_valid;
    ipat_item_t front_item;
    logic       front_ready;

    // queue -> back
    logic       q_valid;
    ipat_item_t q_item;
    logic       q_ready;

    // back -> finish
    logic       snap_valid;
    ipat_snap_t snap;
    logic       snap_ready;

    // classify characters
    ipat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    // decouples classification from parsing
    ipat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_ready  (front_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_ready (q_ready)
    );

    // IPv4 and IPv6 parse state, snapshot at end of text
    ipat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_item),
        .item_ready (q_ready),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    // place groups after "::" and register the result
    ipat_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .result     (result)
    );

    // an end-of-text entry never overwrites a pending snapshot
    `IPAT_ASSERT_IMP(a_last_not_lost, q_valid && q_ready && q_item.last, !snap_valid || snap_ready, "end of text popped while snapshot blocked")

    // a draining snapshot shows up as a result next cycle
    `IPAT_ASSERT_NEXT(a_snap_drains, snap_valid && snap_ready, result.valid, "snapshot drained without result")

    // only the chosen kind carries a value
    `IPAT_ASSERT_IMP(a_v6_no_v4, result.valid && result.is_ipv6, result.ipv4_value == 32'd0, "IPv6 result with IPv4 value")

    `IPAT_ASSERT_IMP(a_v4_no_v6, result.valid && !result.is_ipv6, (result.ipv6_upper == 64'd0) && (result.ipv6_lower == 64'd0), "IPv4 result with IPv6 value")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Character codes the parser reacts to.
localparam logic [7:0] CH_COLON = 8'h3A;
localparam logic [7:0] CH_DOT   = 8'h2E;
localparam logic [7:0] CH_0     = 8'h30;
localparam logic [7:0] CH_9     = 8'h39;
localparam logic [7:0] CH_LA    = 8'h61;
localparam logic [7:0] CH_LF    = 8'h66;
localparam logic [7:0] CH_UA    = 8'h41;
localparam logic [7:0] CH_UF    = 8'h46;

typedef struct packed {
    logic        is_ipv6;
    logic [31:0] ipv4_value;
    logic [63:0] ipv6_upper;
    logic [63:0] ipv6_lower;
} addr_result_t;

// Tracks the parse of the current text and holds the decoded addresses
// still owed by the block, oldest first.
class addr_parse_checker;
    addr_result_t pending[$];
    int           mismatches;

    logic        colon_seen;
    logic [7:0]  octets[ipat_pkg::NUM_OCTETS];
    int          octet_idx;
    logic [15:0] hex_acc;
    logic        grp_open;
    logic        prev_colon;
    logic        compressed;
    logic        v6_stop;
    logic [15:0] lgrp[ipat_pkg::NUM_GROUPS];
    logic [15:0] rgrp[ipat_pkg::NUM_GROUPS];
    int          lcnt;
    int          lcol;
    int          rcnt;
    int          rcol;
    logic        left_any;
    logic        right_any;

    function new();
        mismatches = 0;
        clear();
    endfunction

    function void clear();
        colon_seen = 1'b0;
        foreach (octets[i])
            octets[i] = 8'h00;
        octet_idx  = 0;
        hex_acc    = 16'h0000;
        grp_open   = 1'b0;
        prev_colon = 1'b0;
        compressed = 1'b0;
        v6_stop    = 1'b0;
        foreach (lgrp[i])
        begin
            lgrp[i] = 16'h0000;
            rgrp[i] = 16'h0000;
        end
        lcnt      = 0;
        lcol      = 0;
        rcnt      = 0;
        rcol      = 0;
        left_any  = 1'b0;
        right_any = 1'b0;
    endfunction

    // open group goes to the side of the "::" we are on
    function void close_group();
        if (!grp_open)
            return;
        if (compressed)
        begin
            if (rcnt < ipat_pkg::NUM_GROUPS)
            begin
                rgrp[rcnt] = hex_acc;
                rcnt++;
            end
        end
        else if (lcnt < ipat_pkg::NUM_GROUPS)
        begin
            lgrp[lcnt] = hex_acc;
            lcnt++;
        end
        grp_open = 1'b0;
        hex_acc  = 16'h0000;
    endfunction

    function void hex_or_stop(logic [7:0] c);
        logic [3:0] d;
        logic       ok;
        ok = 1'b1;
        d  = 4'h0;
        if (c >= CH_0 && c <= CH_9)
            d = 4'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF)
            d = 4'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF)
            d = 4'(c - CH_UA + 8'd10);
        else
            ok = 1'b0;
        if (!ok)
        begin
            close_group();
            v6_stop = 1'b1;
        end
        else if (grp_open)
            hex_acc = {hex_acc[11:0], d};
        else
        begin
            hex_acc  = {12'h000, d};
            grp_open = 1'b1;
        end
    endfunction

    function void v6_step(logic [7:0] c);
        if (!compressed)
        begin
            if (v6_stop)
                return;
            if (c == CH_COLON)
            begin
                if (prev_colon)
                begin
                    prev_colon = 1'b0;
                    compressed = 1'b1;
                end
                else
                begin
                    close_group();
                    prev_colon = 1'b1;
                end
                return;
            end
            // a lone colon followed by something else is a separator
            if (prev_colon)
            begin
                prev_colon = 1'b0;
                if (lcol < ipat_pkg::COLON_MAX)
                    lcol++;
            end
            left_any = 1'b1;
            hex_or_stop(c);
        end
        else
        begin
            right_any = 1'b1;
            if (c == CH_COLON)
            begin
                if (rcol < ipat_pkg::COLON_MAX)
                    rcol++;
                if (!v6_stop)
                    close_group();
                return;
            end
            if (v6_stop)
                return;
            hex_or_stop(c);
        end
    endfunction

    function void note_char(logic [7:0] c, logic has_char, logic last);
        addr_result_t r;
        logic [15:0]  seg[ipat_pkg::NUM_GROUPS];
        int           lp;
        int           rp;
        int           start;
        if (has_char)
        begin
            if (c == CH_COLON)
                colon_seen = 1'b1;
            if (octet_idx < ipat_pkg::NUM_OCTETS)
            begin
                if (c == CH_DOT)
                    octet_idx++;
                else if (c >= CH_0 && c <= CH_9)
                    octets[octet_idx] = 8'(octets[octet_idx] * 10 + (c - CH_0));
            end
            v6_step(c);
        end
        if (!last)
            return;

        if (!v6_stop)
            close_group();
        for (int i = 0; i < ipat_pkg::NUM_GROUPS; i++)
            seg[i] = (i < lcnt) ? lgrp[i] : 16'h0000;
        if (compressed)
        begin
            lp    = left_any  ? lcol + 1 : 0;
            rp    = right_any ? rcol + 1 : 0;
            start = lcnt + ipat_pkg::NUM_GROUPS - lp - rp;
            if (start >= 0 && start < ipat_pkg::NUM_GROUPS)
                for (int i = 0; i < rcnt && start + i < ipat_pkg::NUM_GROUPS; i++)
                    seg[start + i] = rgrp[i];
        end
        r.is_ipv6    = colon_seen;
        r.ipv4_value = colon_seen ? 32'h0 : {octets[0], octets[1], octets[2], octets[3]};
        r.ipv6_upper = colon_seen ? {seg[0], seg[1], seg[2], seg[3]} : 64'h0;
        r.ipv6_lower = colon_seen ? {seg[4], seg[5], seg[6], seg[7]} : 64'h0;
        pending.push_back(r);
        clear();
    endfunction

    function void check_result(addr_result_t got);
        addr_result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing pending: v6=%b v4=%h up=%h lo=%h",
                         $realtime, got.is_ipv6, got.ipv4_value, got.ipv6_upper,
                         got.ipv6_lower);
            return;
        end
        want = pending.pop_front();
        if (got.is_ipv6 !== want.is_ipv6 || got.ipv4_value !== want.ipv4_value ||
            got.ipv6_upper !== want.ipv6_upper || got.ipv6_lower !== want.ipv6_lower)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch", $realtime);
                $display("  expected v6=%b v4=%h up=%h lo=%h", want.is_ipv6,
                         want.ipv4_value, want.ipv6_upper, want.ipv6_lower);
                $display("  actual   v6=%b v4=%h up=%h lo=%h", got.is_ipv6,
                         got.ipv4_value, got.ipv6_upper, got.ipv6_lower);
            end
        end
    endfunction
endclass

module testbench;

    // Receiver back-pressure styles; each one runs for a random stretch.
    typedef enum int { RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKED } rx_mode_t;

    logic clk;
    logic rst_n;

    ipat_char_if   chars_if ();
    ipat_result_if res_if ();

    ip_address_text_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (res_if)
    );

    addr_parse_checker sb;

    // text being built, one byte per character
    logic [7:0] txt[$];
    int         burst_left;
    int         items_sent;

    rx_mode_t   rx_mode       = RX_OPEN;
    int         rx_phase_left = 0;
    int         rx_stall_left = 0;
    int         rx_cycle      = 0;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop. Slowest legal run is well under 0.5 ms.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endfunction

    // n hex digits, mixed case
    function void put_hex(int n);
        int v;
        repeat (n)
        begin
            v = $urandom_range(0, 15);
            if (v < 10)
                txt.push_back(CH_0 + 8'(v));
            else if ($urandom_range(0, 1) == 0)
                txt.push_back(CH_LA + 8'(v - 10));
            else
                txt.push_back(CH_UA + 8'(v - 10));
        end
    endfunction

    // One transaction on the char channel. Sender works in bursts: when a
    // burst runs out, valid drops for a random gap before the next burst.
    task send_item(logic [7:0] c, logic has_char, logic last);
        int gap;
        if (burst_left == 0)
        begin
            chars_if.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            // occasionally a long run with no gaps at all
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(50, 200);
            else
                burst_left = $urandom_range(1, 12);
        end
        chars_if.valid       <= 1'b1;
        chars_if.text_byte   <= c;
        chars_if.byte_valid  <= has_char;
        chars_if.end_of_text <= last;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        // accepted at this edge
        sb.note_char(c, has_char, last);
        burst_left--;
        if (has_char || last)
            items_sent++;
    endtask

    // Sends txt as one address text. Empty-character transactions are
    // sprinkled in; the text ends either on its last character or on an
    // empty end marker.
    task send_text(bit empty_end);
        bit end_here;
        for (int i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            end_here = !empty_end && (i == txt.size() - 1);
            send_item(txt[i], 1'b1, end_here);
        end
        if (empty_end || txt.size() == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        txt.delete();
    endtask

    task send_str(string s, bit empty_end);
        put_str(s);
        send_text(empty_end);
    endtask

    // Result side: the ready pattern switches between the styles above.
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       = rx_mode_t'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(20, 200);
        end
        rx_phase_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:
                res_if.ready <= 1'b1;
            RX_RANDOM:
                res_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC:
                res_if.ready <= (rx_cycle % 4 == 0);
            default:
            begin
                // long hold-offs with ready low
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    res_if.ready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    rx_stall_left = $urandom_range(5, 20);
                    res_if.ready <= 1'b0;
                end
                else
                    res_if.ready <= 1'b1;
            end
        endcase
    end

    // Result monitor; values seen here are those before the edge.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.is_ipv6, res_if.ipv4_value,
                             res_if.ipv6_upper, res_if.ipv6_lower});
    end

    initial
    begin
        int    kind;
        int    ngrp;
        int    cpos;
        string alpha;

        rst_n                = 1'b0;
        chars_if.valid       = 1'b0;
        chars_if.text_byte   = 8'h00;
        chars_if.byte_valid  = 1'b0;
        chars_if.end_of_text = 1'b0;
        sb                   = new();
        burst_left           = 0;
        items_sent           = 0;
        alpha                = ":.0123456789abcdefABCDEFgx/ ";

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed texts ----
        send_str("", 1'b1);                        // empty text
        send_str("0.0.0.0", 1'b0);
        send_str("255.255.255.255", 1'b1);
        send_str("999.256.1.2.3.4", 1'b0);         // octet wrap, extra dots
        send_str("1a2b.3x4 .5", 1'b0);             // foreign chars in IPv4
        send_str("::", 1'b0);
        send_str(":", 1'b1);                       // single colon
        send_str("::1", 1'b0);
        send_str("1::", 1'b0);
        send_str("ffff:FFFF:0:1:2:3:4:5", 1'b0);   // full, mixed case
        send_str("1:2:3:4:5:6:7:8:9:a", 1'b0);     // more than eight groups
        send_str("12345:1::2", 1'b0);              // group wraps mod 65536
        send_str("1:2::3:4", 1'b1);
        send_str("1:g:2::3", 1'b0);                // bad char before "::"
        send_str("1::2:z:3:4", 1'b0);              // bad char after "::"
        send_str("1::2::3", 1'b0);                 // second "::"
        send_str("1:2:3:4:5:6:7:8:9:a:b:c:d:e:f:0:1::2", 1'b0); // left colons saturate
        put_str("a::");
        put_str("::::::::::::::::");               // 16 right colons, saturate
        send_str("b", 1'b0);
        send_str("::ffff:1.2.3.4", 1'b0);          // dot ends IPv6 after "::"
        send_str("1.2.3.4:", 1'b0);                // trailing colon makes it IPv6

        // ---- random texts ----
        while (items_sent < 1200)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                // IPv6-shaped: 0..9 groups, optional "::" anywhere
                ngrp = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0)
                    cpos = -1;
                else
                    cpos = $urandom_range(0, ngrp);
                if ($urandom_range(0, 15) == 0)
                    put_str(":");
                for (int i = 0; i < ngrp; i++)
                begin
                    if (i == cpos)
                        put_str("::");
                    else if (i > 0)
                        put_str(":");
                    if ($urandom_range(0, 9) == 0)
                        put_hex(5);
                    else
                        put_hex($urandom_range(1, 4));
                end
                if (cpos == ngrp)
                    put_str("::");
                if ($urandom_range(0, 15) == 0)
                    put_str(":");
                if ($urandom_range(0, 11) == 0)
                    put_str($sformatf(".%0d.%0d", $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
            end
            else if (kind < 7)
            begin
                // dotted decimal, sometimes out-of-range octets
                for (int i = 0; i < 4; i++)
                begin
                    if (i > 0)
                        put_str(".");
                    if ($urandom_range(0, 7) == 0)
                        put_str($sformatf("%0d", $urandom_range(0, 999)));
                    else
                        put_str($sformatf("%0d", $urandom_range(0, 255)));
                end
                if ($urandom_range(0, 7) == 0)
                    put_str(".7.");
            end
            else if (kind < 9)
            begin
                // noise over the characters the parser cares about
                repeat ($urandom_range(1, 20))
                    txt.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
            end
            else
            begin
                // raw bytes
                repeat ($urandom_range(0, 12))
                    txt.push_back(8'($urandom_range(0, 255)));
            end
            // corrupt one character of some well-formed texts
            if (kind < 7 && txt.size() > 0 && $urandom_range(0, 7) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            send_text($urandom_range(0, 3) == 0);
        end
        chars_if.valid <= 1'b0;

        // drain, then give the pipeline time to show any stray result
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
